### sv/merge_sorter_unit_defines.svh
// assertion macros for the merge sorter unit
`ifndef MERGE_SORTER_UNIT_DEFINES_SVH
`define MERGE_SORTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define MSU_ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: check failed");

`define MSU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

`else

`define MSU_ASSERT_ALWAYS(lbl, clk, rst, prop)

`define MSU_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`endif

`endif

### sv/msort_pkg.sv
// shared types and constants for the merge sorter
`timescale 1ns / 1ps
`default_nettype none

package msort_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic load_we;
    logic merge_we;
    logic src_sel;
    logic fetch;
    logic merge;
    logic out_ld;
    logic last_out;
    logic dropped;
    logic a_done;
    logic b_done;
  } ctl_t;

endpackage

`default_nettype wire

### sv/msort_ram.sv
// generic single write, single registered read RAM
`timescale 1ns / 1ps
`default_nettype none

module msort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### sv/msort_ctrl.sv
// sequencer for load, bottom-up merge passes and emission
`timescale 1ns / 1ps
`default_nettype none
`include "merge_sorter_unit_defines.svh"

module msort_ctrl import msort_pkg::*; #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  input  wire logic          item_last,
  input  wire logic          result_stall,
  input  wire logic          take_a,
  output logic               item_stall,
  output logic [AW-1:0]      rd_addr,
  output logic [AW-1:0]      wr_addr,
  output ctl_t               ctl
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = CW + 2;

  localparam logic [2:0] S_LOAD      = 3'd0;
  localparam logic [2:0] S_RUN       = 3'd1;
  localparam logic [2:0] S_FETCH     = 3'd2;
  localparam logic [2:0] S_MERGE     = 3'd3;
  localparam logic [2:0] S_EMIT_RD   = 3'd4;
  localparam logic [2:0] S_EMIT_LD   = 3'd5;
  localparam logic [2:0] S_EMIT_WAIT = 3'd6;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic          dropped;
  logic          src;
  logic [EW-1:0] width;
  logic [EW-1:0] lo;
  logic [EW-1:0] mid;
  logic [EW-1:0] hi;
  logic [EW-1:0] ia;
  logic [EW-1:0] ib;
  logic [EW-1:0] k;

  logic          accept;
  logic          room;
  logic [EW-1:0] n_e;
  logic [EW-1:0] lo_w;
  logic [EW-1:0] lo_2w;
  logic [EW-1:0] mid_c;
  logic [EW-1:0] hi_c;
  logic [EW-1:0] k_inc;
  logic [EW-1:0] ia_inc;
  logic [EW-1:0] ib_inc;
  logic [EW-1:0] w2;
  logic          run_end;
  logic          pass_end;
  logic          sort_end;

  assign item_stall = (state != S_LOAD);
  assign accept     = item_valid & ~item_stall;
  assign room       = (count < CW'(DEPTH));
  assign n_e        = EW'(count);
  assign w2         = width << 1;
  assign lo_w       = lo + width;
  assign lo_2w      = lo + w2;
  assign mid_c      = (lo_w < n_e) ? lo_w : n_e;
  assign hi_c       = (lo_2w < n_e) ? lo_2w : n_e;
  assign k_inc      = k + EW'(1);
  assign ia_inc     = ia + EW'(1);
  assign ib_inc     = ib + EW'(1);
  assign run_end    = (k_inc == hi);
  assign pass_end   = (lo_2w >= n_e);
  assign sort_end   = (w2 >= n_e);

  always_comb begin
    unique case (state)
      S_RUN:       rd_addr = lo[AW-1:0];
      S_FETCH:     rd_addr = mid[AW-1:0];
      S_MERGE:     rd_addr = take_a ? ia_inc[AW-1:0] : ib_inc[AW-1:0];
      S_EMIT_RD:   rd_addr = k[AW-1:0];
      S_EMIT_WAIT: rd_addr = k_inc[AW-1:0];
      default:     rd_addr = '0;
    endcase
  end

  assign wr_addr = (state == S_LOAD) ? count[AW-1:0] : k[AW-1:0];

  always_comb begin
    ctl.load_we  = accept & room;
    ctl.merge_we = (state == S_MERGE);
    ctl.src_sel  = src;
    ctl.fetch    = (state == S_FETCH);
    ctl.merge    = (state == S_MERGE);
    ctl.out_ld   = (state == S_EMIT_LD);
    ctl.last_out = (k_inc == n_e);
    ctl.dropped  = dropped;
    ctl.a_done   = (ia >= mid);
    ctl.b_done   = (ib >= hi);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (item_last) begin
              width <= EW'(1);
              lo    <= '0;
              src   <= 1'b0;
              k     <= '0;
              // a single element needs no merging
              state <= (count == '0) ? S_EMIT_RD : S_RUN;
            end
          end
        end
        S_RUN: begin
          mid   <= mid_c;
          hi    <= hi_c;
          ia    <= lo;
          ib    <= mid_c;
          k     <= lo;
          state <= S_FETCH;
        end
        S_FETCH: begin
          state <= S_MERGE;
        end
        S_MERGE: begin
          if (take_a) begin
            ia <= ia_inc;
          end else begin
            ib <= ib_inc;
          end
          if (run_end) begin
            if (pass_end) begin
              src   <= ~src;
              lo    <= '0;
              width <= w2;
              if (sort_end) begin
                k     <= '0;
                state <= S_EMIT_RD;
              end else begin
                state <= S_RUN;
              end
            end else begin
              lo    <= lo_2w;
              state <= S_RUN;
            end
          end else begin
            k <= k_inc;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          state <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (!result_stall) begin
            if (ctl.last_out) begin
              count   <= '0;
              dropped <= 1'b0;
              state   <= S_LOAD;
            end else begin
              k     <= k_inc;
              state <= S_EMIT_LD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  `MSU_ASSERT_ALWAYS(a_count_cap, clk, rst, count <= CW'(DEPTH))
  `MSU_ASSERT_IMPL(a_merge_in_run, clk, rst, state == S_MERGE, k < hi)
  `MSU_ASSERT_IMPL(a_emit_in_set, clk, rst, state == S_EMIT_WAIT, k < n_e)
  `MSU_ASSERT_IMPL(a_run_start, clk, rst, state == S_RUN, lo < n_e)

endmodule

`default_nettype wire

### sv/merge_sorter_unit.sv
// merge sorter top level: stores a set, sorts it by merging, emits it
//
// item channel: item_valid/item_stall carry value and is_last. one beat is
// taken per cycle while a set is loading; the beat with is_last closes the
// set. at most DEPTH beats are kept, later ones are dropped and the set's
// results carry overflow.
// after the closing beat item_stall stays high while the set is sorted and
// emitted. sorting runs ceil(log2 n) merge passes over two ping-pong RAMs;
// each pass is bounded by one compare and one RAM read port. results
// follow the sort one at a time; each is loaded into the output register
// only after the previous one is taken.
// result channel: result_valid/result_stall carry value_res, is_last_res
// and overflow from an output register; a stalled beat holds until taken.
// the next set is taken once the result marked is_last_res is accepted.
// reset (rst, synchronous) empties the store and returns to loading.
`timescale 1ns / 1ps
`default_nettype none

module merge_sorter_unit import msort_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   item_valid,
  output logic        item_stall,
  input  wire value_t value,
  input  wire logic   is_last,
  output logic        result_valid,
  input  wire logic   result_stall,
  output value_t      value_res,
  output logic        is_last_res,
  output logic        overflow
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ctl_t                ctl;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;
  logic                take_a;
  logic [VALUE_W-1:0]  rd0;
  logic [VALUE_W-1:0]  rd1;
  logic [VALUE_W-1:0]  wr_data;
  value_t              rd_data;
  value_t              a_head;
  value_t              b_head;
  value_t              a_cur;
  value_t              b_cur;
  value_t              merge_data;
  logic                fresh_a;
  logic                key_lt;

  msort_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_last    (is_last),
    .result_stall (result_stall),
    .take_a       (take_a),
    .item_stall   (item_stall),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .ctl          (ctl)
  );

  msort_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram0 (
    .clk     (clk),
    .we      (ctl.load_we | (ctl.merge_we & ctl.src_sel)),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd0)
  );

  msort_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram1 (
    .clk     (clk),
    .we      (ctl.merge_we & ~ctl.src_sel),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd1)
  );

  assign rd_data = ctl.src_sel ? $signed(rd1) : $signed(rd0);

  // the side consumed last cycle is refilled straight from the read port
  assign a_cur      = fresh_a ? rd_data : a_head;
  assign b_cur      = fresh_a ? b_head : rd_data;
  assign key_lt     = (a_cur < b_cur);
  assign take_a     = ctl.b_done | (~ctl.a_done & key_lt);
  assign merge_data = take_a ? a_cur : b_cur;
  assign wr_data    = ctl.merge ? $unsigned(merge_data) : $unsigned(value);

  always_ff @(posedge clk) begin
    if (ctl.fetch) begin
      a_head  <= rd_data;
      fresh_a <= 1'b0;
    end else if (ctl.merge) begin
      a_head  <= a_cur;
      b_head  <= b_cur;
      fresh_a <= take_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.out_ld) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      value_res   <= rd_data;
      is_last_res <= ctl.last_out;
      overflow    <= ctl.dropped;
    end
  end

endmodule

`default_nettype wire
